### src/kwm_pkg.sv
// shared constants, codes and types for the k-way sorted merge unit
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int NUM_LISTS  = 8;
  localparam int LIST_DEPTH = 64;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int POS_W  = $clog2(LIST_DEPTH);
  localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W = IDX_W + POS_W;
  localparam int STORE_DEPTH = NUM_LISTS * LIST_DEPTH;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_TAKE   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic             valid;
    logic             has;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] pos;
  } head_t;

  typedef struct packed {
    logic                     found;
    logic [IDX_W-1:0]         idx;
    logic [CNT_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
  } best_t;

endpackage

### src/kwm_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/kwm_min_unit.sv
// shared signed compare unit that tracks the smallest list head during a scan
`timescale 1ns / 1ps

module kwm_min_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             init,
  input  kwm_pkg::head_t                   head,
  input  logic signed [kwm_pkg::DATA_W-1:0] data,
  output kwm_pkg::best_t                   best
);

  logic better;

  assign better = head.valid && head.has && (!best.found || (data < best.val));

  always_ff @(posedge clk) begin
    if (rst || init) begin
      best.found <= 1'b0;
    end else if (better) begin
      best.found <= 1'b1;
    end
    if (better) begin
      best.idx <= head.idx;
      best.pos <= head.pos;
      best.val <= data;
    end
  end

endmodule

### src/k_way_sorted_merge_unit.sv
// top level: k-way merge of ascending signed lists held in one shared store
//
//   channel  | handshake           | fields
//   ---------+---------------------+-----------------------------
//   command  | start, busy         | op, list_index, value
//   result   | done (one cycle)    | status, merged_value
//
// append, clear and unused op: S_APP or S_MISC registers the result and raises done
// take: S_SCAN does one head read from the store ram per cycle through the shared
//   compare unit, then S_LAST and S_FIN follow, and S_FIN raises done
// busy is high from accept until the cycle done is raised
// rst clears the list counters; store contents and tails need no reset
// done is not held off: each result lasts exactly one cycle
`timescale 1ns / 1ps

module k_way_sorted_merge_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          op,
  input  logic [kwm_pkg::IDX_W-1:0]           list_index,
  input  logic signed [kwm_pkg::DATA_W-1:0]   value,
  output logic                                done,
  output logic [1:0]                          status,
  output logic signed [kwm_pkg::DATA_W-1:0]   merged_value
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_APP  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_MISC = 3'd5;

  logic [2:0] state;
  logic [1:0] op_r;
  logic [kwm_pkg::IDX_W-1:0] cur;
  logic signed [kwm_pkg::DATA_W-1:0] value_r;

  logic [kwm_pkg::CNT_W-1:0] wpos [kwm_pkg::NUM_LISTS];
  logic [kwm_pkg::CNT_W-1:0] rpos [kwm_pkg::NUM_LISTS];
  logic signed [kwm_pkg::DATA_W-1:0] tail [kwm_pkg::NUM_LISTS];

  logic [kwm_pkg::CNT_W-1:0] wpos_cur;
  logic [kwm_pkg::CNT_W-1:0] rpos_cur;
  logic signed [kwm_pkg::DATA_W-1:0] tail_cur;
  logic idx_bad;
  logic [1:0] app_status;
  logic app_ok;

  kwm_pkg::head_t head;
  kwm_pkg::best_t best;
  logic init;
  logic [kwm_pkg::DATA_W-1:0] rdata;
  logic [kwm_pkg::ADDR_W-1:0] raddr;
  logic [kwm_pkg::ADDR_W-1:0] waddr;

  assign busy     = (state != S_IDLE);
  assign init     = start && !busy;
  assign wpos_cur = wpos[cur];
  assign rpos_cur = rpos[cur];
  assign tail_cur = tail[cur];
  assign idx_bad  = ({1'b0, cur} >= (kwm_pkg::IDX_W + 1)'(kwm_pkg::NUM_LISTS));
  assign raddr    = {cur, rpos_cur[kwm_pkg::POS_W-1:0]};
  assign waddr    = {cur, wpos_cur[kwm_pkg::POS_W-1:0]};

  always_comb begin
    if (idx_bad || (wpos_cur >= kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH))) begin
      app_status = kwm_pkg::ST_FULL;
    end else if ((wpos_cur != '0) && (value_r < tail_cur)) begin
      app_status = kwm_pkg::ST_ORDER;
    end else begin
      app_status = kwm_pkg::ST_OK;
    end
  end

  assign app_ok = (state == S_APP) && (app_status == kwm_pkg::ST_OK);

  kwm_ram #(
    .WIDTH(kwm_pkg::DATA_W),
    .DEPTH(kwm_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (app_ok),
    .waddr(waddr),
    .wdata(value_r),
    .raddr(raddr),
    .rdata(rdata)
  );

  kwm_min_unit u_min (
    .clk (clk),
    .rst (rst),
    .init(init),
    .head(head),
    .data($signed(rdata)),
    .best(best)
  );

  always_ff @(posedge clk) begin
    if (app_ok) begin
      tail[cur] <= value_r;
    end
    if (init) begin
      op_r    <= op;
      value_r <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      cur        <= '0;
      head.valid <= 1'b0;
      for (int k = 0; k < kwm_pkg::NUM_LISTS; k++) begin
        wpos[k] <= '0;
        rpos[k] <= '0;
      end
    end else begin
      done       <= 1'b0;
      head.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= (op == kwm_pkg::OP_APPEND) ? list_index : '0;
            case (op)
              kwm_pkg::OP_APPEND: state <= S_APP;
              kwm_pkg::OP_TAKE:   state <= S_SCAN;
              default:            state <= S_MISC;
            endcase
          end
        end
        S_APP: begin
          if (app_ok) begin
            wpos[cur] <= wpos_cur + 1'b1;
          end
          status       <= app_status;
          merged_value <= '0;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        S_SCAN: begin
          head.valid <= 1'b1;
          head.has   <= (rpos_cur < wpos_cur);
          head.idx   <= cur;
          head.pos   <= rpos_cur;
          cur        <= cur + 1'b1;
          if (cur == kwm_pkg::IDX_W'(kwm_pkg::NUM_LISTS - 1)) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (best.found) begin
            rpos[best.idx] <= best.pos + 1'b1;
            status         <= kwm_pkg::ST_OK;
            merged_value   <= best.val;
          end else begin
            status       <= kwm_pkg::ST_EMPTY;
            merged_value <= '0;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_MISC: begin
          if (op_r == kwm_pkg::OP_CLEAR) begin
            for (int k = 0; k < kwm_pkg::NUM_LISTS; k++) begin
              wpos[k] <= '0;
              rpos[k] <= '0;
            end
          end
          status       <= kwm_pkg::ST_OK;
          merged_value <= '0;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a command in flight");

  a_busy_ends_with_done: assert property (@(posedge clk) disable iff (rst || $past(rst))
    $fell(busy) |-> done)
    else $error("command finished without a result word");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == kwm_pkg::ST_EMPTY)) |-> (merged_value == '0))
    else $error("empty take returned a nonzero value");

  for (genvar g = 0; g < kwm_pkg::NUM_LISTS; g++) begin : g_pos_chk
    a_pos_order: assert property (@(posedge clk) disable iff (rst)
      (rpos[g] <= wpos[g]) && (wpos[g] <= kwm_pkg::CNT_W'(kwm_pkg::LIST_DEPTH)))
      else $error("list read position passed its write position");
  end

endmodule
